FILE: sv/tick_task_compare_scheduler_core_defines.svh
// Assertion macros shared by the tick task compare scheduler RTL.
`ifndef TICK_TASK_COMPARE_SCHEDULER_CORE_DEFINES_SVH
`define TICK_TASK_COMPARE_SCHEDULER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TTCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TTCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define TTCS_ASSERT(lbl, prop, msg)
`define TTCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/ttcs_pkg.sv
// Shared constants, operation codes and controller/datapath types.
package ttcs_pkg;

   localparam int NUM_TASKS_DEF = 3;
   localparam int OP_W          = 2;
   localparam int IDX_IN_W      = 2;
   localparam int PERIOD_W      = 24;
   localparam int COUNT_W       = 16;
   localparam int DIV_STEPS     = PERIOD_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   localparam logic [COUNT_W-1:0] TOP_RESET = '1;

   localparam logic [OP_W-1:0] OP_ARM     = 2'd0;
   localparam logic [OP_W-1:0] OP_WRAP    = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPARE = 2'd2;

   typedef struct packed {
      logic capture;
      logic clr_ptr;
      logic inc_ptr;
      logic act_direct;
      logic div_start;
      logic act_div;
      logic wrap_dec;
      logic min_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            act_needed;
      logic            near;
      logic            ptr_last;
      logic            div_done;
   } sts_type;

endpackage

FILE: sv/ttcs_div.sv
// Restoring divider, one quotient bit per cycle, for splitting a period into wraps.
`include "tick_task_compare_scheduler_core_defines.svh"
module ttcs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ttcs_pkg::PERIOD_W-1:0]     dividend,
   input  logic [ttcs_pkg::COUNT_W-1:0]      divisor,
   output logic [ttcs_pkg::PERIOD_W-1:0]     quotient,
   output logic [ttcs_pkg::COUNT_W-1:0]      remainder,
   output logic                              done
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [ttcs_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic [ttcs_pkg::PERIOD_W-1:0]     quo_ff;
   logic [ttcs_pkg::COUNT_W-1:0]      rem_ff;
   logic [ttcs_pkg::COUNT_W-1:0]      div_ff;
   logic [ttcs_pkg::COUNT_W:0]        shifted;
   logic                              ge;
   logic [ttcs_pkg::COUNT_W-1:0]      rem_in;

   assign shifted = {rem_ff, quo_ff[ttcs_pkg::PERIOD_W-1]};
   assign ge      = shifted >= {1'b0, div_ff};
   // partial remainder stays below the divisor, so 16 bits suffice
   assign rem_in  = ge ? ttcs_pkg::COUNT_W'(shifted - {1'b0, div_ff})
                       : shifted[ttcs_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == ttcs_pkg::DIV_CNT_W'(ttcs_pkg::DIV_STEPS - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == ttcs_pkg::DIV_CNT_W'(ttcs_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[ttcs_pkg::PERIOD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   `TTCS_ASSERT_NEXT(a_div_start_busy, start, busy_ff, "divider did not go busy after start")
   `TTCS_ASSERT(a_div_no_restart, start |-> !busy_ff, "divider restarted while busy")
   `TTCS_ASSERT(a_div_done_idle, done_ff |-> !busy_ff, "divider done while still busy")

endmodule

FILE: sv/ttcs_datapath.sv
// Task state, transaction capture, arming arithmetic, minimum sweep and result register.
module ttcs_datapath #(
   parameter int NUM_TASKS = ttcs_pkg::NUM_TASKS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [ttcs_pkg::COUNT_W-1:0]       csr_counter_top,
   input  logic [ttcs_pkg::OP_W-1:0]          req_operation,
   input  logic [ttcs_pkg::IDX_IN_W-1:0]      req_task_index,
   input  logic [ttcs_pkg::PERIOD_W-1:0]      req_period_ticks,
   input  logic [ttcs_pkg::COUNT_W-1:0]       req_counter_now,
   input  ttcs_pkg::cmd_type                  cmd,
   output ttcs_pkg::sts_type                  sts,
   output logic [NUM_TASKS-1:0]               rsp_fired_mask,
   output logic [ttcs_pkg::COUNT_W-1:0]       rsp_compare_value,
   output logic                               rsp_compare_enable
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int PW    = ttcs_pkg::PERIOD_W;
   localparam int CW    = ttcs_pkg::COUNT_W;

   logic [CW-1:0]                 top_ff;
   logic [ttcs_pkg::OP_W-1:0]     op_ff;
   logic [ttcs_pkg::IDX_IN_W-1:0] idx_ff;
   logic [PW-1:0]                 per_ff;
   logic [CW-1:0]                 now_ff;
   logic [IDX_W-1:0]              ptr_ff;
   logic [NUM_TASKS-1:0]          armed_ff;
   logic [PW-1:0]                 period_ff [NUM_TASKS];
   logic [PW-1:0]                 wraps_ff  [NUM_TASKS];
   logic [CW-1:0]                 offset_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0]          fired_ff;
   logic [CW-1:0]                 best_ff;
   logic                          any_ff;
   logic [NUM_TASKS-1:0]          rsp_fired_ff;
   logic [CW-1:0]                 rsp_value_ff;
   logic                          rsp_enable_ff;

   logic [PW-1:0] ticks;
   logic [CW-1:0] left;
   logic [PW-1:0] rest;
   logic [CW-1:0] divisor;
   logic [CW-1:0] near_offset;
   logic [PW-1:0] quotient;
   logic [CW-1:0] remainder;
   logic          div_done;
   logic [PW-1:0] wraps_in;
   logic [CW-1:0] offset_in;
   logic          due;
   logic          arm_target;
   logic          act;
   logic          cur_valid;

   // current task's operands
   assign ticks       = (op_ff == ttcs_pkg::OP_ARM) ? per_ff : period_ff[ptr_ff];
   assign left        = top_ff - now_ff;
   assign rest        = ticks - PW'(left);
   assign divisor     = (top_ff == '0) ? CW'(1) : top_ff;
   assign near_offset = ticks[CW-1:0] + now_ff;
   // wraps = quotient + 1, saturating
   assign wraps_in    = act && cmd.act_div ? ((quotient == '1) ? quotient : quotient + 1'b1)
                                           : '0;
   assign offset_in   = cmd.act_div ? remainder : near_offset;
   assign act         = cmd.act_direct || cmd.act_div;

   assign cur_valid  = armed_ff[ptr_ff] && (wraps_ff[ptr_ff] == '0);
   assign due        = cur_valid && (offset_ff[ptr_ff] <= now_ff);
   assign arm_target = (op_ff == ttcs_pkg::OP_ARM) && (8'(ptr_ff) == 8'(idx_ff));

   assign sts.op         = op_ff;
   assign sts.act_needed = arm_target || ((op_ff == ttcs_pkg::OP_COMPARE) && due);
   assign sts.near       = ticks < PW'(left);
   assign sts.ptr_last   = ptr_ff == IDX_W'(NUM_TASKS - 1);
   assign sts.div_done   = div_done;

   ttcs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rest),
      .divisor   (divisor),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= ttcs_pkg::TOP_RESET;
         ptr_ff   <= '0;
         armed_ff <= '0;
      end else begin
         if (csr_valid) begin
            top_ff <= csr_counter_top;
         end
         if (cmd.clr_ptr) begin
            ptr_ff <= '0;
         end else if (cmd.inc_ptr) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (act) begin
            armed_ff[ptr_ff] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         idx_ff   <= req_task_index;
         per_ff   <= req_period_ticks;
         now_ff   <= req_counter_now;
         fired_ff <= '0;
         best_ff  <= '0;
         any_ff   <= 1'b0;
      end
      if (act) begin
         wraps_ff[ptr_ff]  <= wraps_in;
         offset_ff[ptr_ff] <= offset_in;
         if (op_ff == ttcs_pkg::OP_ARM) begin
            period_ff[ptr_ff] <= per_ff;
         end
         if (op_ff == ttcs_pkg::OP_COMPARE) begin
            fired_ff[ptr_ff] <= 1'b1;
         end
      end
      if (cmd.wrap_dec && armed_ff[ptr_ff] && (wraps_ff[ptr_ff] != '0)) begin
         wraps_ff[ptr_ff] <= wraps_ff[ptr_ff] - 1'b1;
      end
      if (cmd.min_step && cur_valid && (!any_ff || (offset_ff[ptr_ff] < best_ff))) begin
         best_ff <= offset_ff[ptr_ff];
         any_ff  <= 1'b1;
      end else if (cmd.min_step && cur_valid) begin
         any_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_fired_ff  <= fired_ff;
         rsp_value_ff  <= best_ff;
         rsp_enable_ff <= any_ff;
      end
   end

   assign rsp_fired_mask     = rsp_fired_ff;
   assign rsp_compare_value  = rsp_value_ff;
   assign rsp_compare_enable = rsp_enable_ff;

endmodule

FILE: sv/ttcs_ctrl.sv
// Sequencing state machine: task scan, divide wait, minimum sweep, result handoff.
`include "tick_task_compare_scheduler_core_defines.svh"
module ttcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ttcs_pkg::sts_type sts,
   output ttcs_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MIN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.clr_ptr = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.act_needed && !sts.near) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.act_direct = sts.act_needed;
               cmd.wrap_dec   = (sts.op == ttcs_pkg::OP_WRAP);
               if (sts.ptr_last) begin
                  cmd.clr_ptr = 1'b1;
                  state_in    = ST_MIN;
               end else begin
                  cmd.inc_ptr = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.act_div = 1'b1;
               if (sts.ptr_last) begin
                  cmd.clr_ptr = 1'b1;
                  state_in    = ST_MIN;
               end else begin
                  cmd.inc_ptr = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_MIN: begin
            cmd.min_step = 1'b1;
            if (sts.ptr_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.inc_ptr = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `TTCS_ASSERT_NEXT(a_ctrl_one_at_a_time, req_valid && req_ready, !req_ready,
                     "second transaction taken while one is in progress")
   `TTCS_ASSERT(a_ctrl_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE,
                "response raised outside the handoff state")
   `TTCS_ASSERT_NEXT(a_ctrl_div_wait, cmd.div_start, state_ff == ST_DIV,
                     "divide started without waiting for it")

endmodule

FILE: sv/tick_task_compare_scheduler_core.sv
// Sequence: after accept, the task scan, the minimum sweep and the handoff state lead
//   to rsp_valid, plus a divide wait (one 24-step restoring divide) for each task
//   whose new period reaches past the next wrap. A new transaction is taken only
//   after the previous one has left the handoff state.
// Reset: synchronous, active high; disarms all tasks, sets counter_top to 65535 and
//   clears rsp_valid; the result register contents are not reset.
module tick_task_compare_scheduler_core #(
   parameter int NUM_TASKS = ttcs_pkg::NUM_TASKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write channel: counter_top
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ttcs_pkg::COUNT_W-1:0]      csr_counter_top,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ttcs_pkg::OP_W-1:0]         req_operation,
   input  logic [ttcs_pkg::IDX_IN_W-1:0]     req_task_index,
   input  logic [ttcs_pkg::PERIOD_W-1:0]     req_period_ticks,
   input  logic [ttcs_pkg::COUNT_W-1:0]      req_counter_now,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [NUM_TASKS-1:0]              rsp_fired_mask,
   output logic [ttcs_pkg::COUNT_W-1:0]      rsp_compare_value,
   output logic                              rsp_compare_enable
);

   // Each request transaction is captured, then the controller walks the tasks once:
   //  - arm: the addressed task is split into wraps and an offset
   //  - wrap: every armed task with wraps outstanding counts down by one
   //  - compare: every due task fires and is re-armed from the current count
   // Arming within the current round is a single add; arming past the wrap goes through
   // the divider (rest / counter_top gives wraps - 1, the remainder the offset).
   // A second walk then finds the smallest offset among armed tasks with no wraps left.
   // The result sits in an output register, so a new request can be taken while the
   // previous response is still waiting for rsp_ready.

   ttcs_pkg::cmd_type cmd;
   ttcs_pkg::sts_type sts;

   // counter_top is a plain register; writes are always taken
   assign csr_ready = 1'b1;

   ttcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ttcs_datapath #(
      .NUM_TASKS (NUM_TASKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_counter_top    (csr_counter_top),
      .req_operation      (req_operation),
      .req_task_index     (req_task_index),
      .req_period_ticks   (req_period_ticks),
      .req_counter_now    (req_counter_now),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_fired_mask     (rsp_fired_mask),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_compare_enable (rsp_compare_enable)
   );

endmodule

FILE: bench/tick_task_compare_scheduler_core_test.sv
// Self-checking bench for the tick task compare scheduler core: directed and random transactions.
module tick_task_compare_scheduler_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASKS         = ttcs_pkg::NUM_TASKS_DEF;
   localparam int OP_W          = ttcs_pkg::OP_W;
   localparam int IDX_IN_W      = ttcs_pkg::IDX_IN_W;
   localparam int PERIOD_W      = ttcs_pkg::PERIOD_W;
   localparam int COUNT_W       = ttcs_pkg::COUNT_W;
   localparam int CLK_PERIOD    = 20;
   // operation code 3 has no meaning in the block; it must leave all state alone
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   // worst-case accept-to-response latency: scan plus one divide per task, with margin
   localparam int SETTLE_CYCLES = 2*TASKS + 2 + 25*TASKS + 16;
   localparam int CYCLE_LIMIT   = 400000;
   // the response side stops taking results once this many transactions are in
   localparam int HOLD_AT       = 330;
   localparam int HOLD_CYCLES   = 400;
   // window (in accepted transactions) where neither side idles
   localparam int CALM_FROM     = 180;
   localparam int CALM_TO       = 240;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [IDX_IN_W-1:0] index;
      logic [PERIOD_W-1:0] period;
      logic [COUNT_W-1:0]  now;
   } sched_item_type;

   typedef struct {
      logic [TASKS-1:0]   fired;
      logic [COUNT_W-1:0] value;
      logic               enable;
   } sched_outcome_type;

   // ---------------------------------------------------------------- DUT ports
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_counter_top = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = '0;
   logic [IDX_IN_W-1:0] req_task_index = '0;
   logic [PERIOD_W-1:0] req_period_ticks = '0;
   logic [COUNT_W-1:0]  req_counter_now = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TASKS-1:0]    rsp_fired_mask;
   logic [COUNT_W-1:0]  rsp_compare_value;
   logic                rsp_compare_enable;

   // ---------------------------------------------------------------- bench state
   sched_item_type    pending_items[$];
   sched_outcome_type awaited_outcomes[$];
   int                queued_count   = 0;
   int                accepted_count = 0;
   int                fault_count    = 0;
   int                cycle_count    = 0;
   int                hold_left      = 0;
   bit                hold_done      = 1'b0;
   bit                req_accepted   = 1'b0;
   wire               calm = (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);

   // shadow of the scheduler: one entry per task plus the counter top
   logic                task_live   [TASKS];
   logic [PERIOD_W-1:0] task_ticks  [TASKS];
   logic [PERIOD_W-1:0] task_wraps  [TASKS];
   logic [COUNT_W-1:0]  task_offset [TASKS];
   logic [COUNT_W-1:0]  top_shadow;

   tick_task_compare_scheduler_core #(
      .NUM_TASKS (TASKS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_counter_top    (csr_counter_top),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_task_index     (req_task_index),
      .req_period_ticks   (req_period_ticks),
      .req_counter_now    (req_counter_now),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_fired_mask     (rsp_fired_mask),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_compare_enable (rsp_compare_enable)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Split the stored period of task t into whole wraps still to come and an
   // offset within the last counter round, measured from the count 'now'.
   function automatic void rearm_task(input int t, input logic [COUNT_W-1:0] now);
      logic [PERIOD_W-1:0] ticks;
      logic [COUNT_W-1:0]  left;
      logic [PERIOD_W-1:0] divisor;
      logic [PERIOD_W-1:0] rest;
      logic [PERIOD_W:0]   wraps;
      ticks = task_ticks[t];
      left  = top_shadow - now;            // modulo 2^16, so a count beyond top wraps
      if (ticks < PERIOD_W'(left)) begin
         task_offset[t] = ticks[COUNT_W-1:0] + now;
         task_wraps[t]  = '0;
      end else begin
         // a zero top divides as one
         divisor = (top_shadow == '0) ? PERIOD_W'(1) : PERIOD_W'(top_shadow);
         rest    = ticks - PERIOD_W'(left);
         wraps   = (PERIOD_W+1)'(rest / divisor) + (PERIOD_W+1)'(1);
         // pending wraps saturate at the 24-bit ceiling
         task_wraps[t]  = wraps[PERIOD_W] ? '1 : wraps[PERIOD_W-1:0];
         task_offset[t] = COUNT_W'(rest % divisor);
      end
      task_live[t] = 1'b1;
   endfunction

   // Apply one transaction to the shadow and return the response it should raise.
   function automatic sched_outcome_type schedule_step(input sched_item_type it);
      sched_outcome_type res;
      int                i;
      res.fired  = '0;
      res.value  = '0;
      res.enable = 1'b0;
      case (it.op)
         ttcs_pkg::OP_ARM: begin
            // an index past the last task is dropped silently
            if (it.index < TASKS) begin
               task_ticks[it.index] = it.period;
               rearm_task(int'(it.index), it.now);
            end
         end
         ttcs_pkg::OP_WRAP: begin
            for (i = 0; i < TASKS; i++)
               if (task_live[i] && task_wraps[i] != '0)
                  task_wraps[i] = task_wraps[i] - 1'b1;
         end
         ttcs_pkg::OP_COMPARE: begin
            for (i = 0; i < TASKS; i++) begin
               if (task_live[i] && task_wraps[i] == '0 && task_offset[i] <= it.now) begin
                  res.fired[i] = 1'b1;
                  rearm_task(i, it.now);
               end
            end
         end
         default: ;
      endcase
      // plain minimum over tasks due before the next wrap; zero when none
      for (i = 0; i < TASKS; i++) begin
         if (task_live[i] && task_wraps[i] == '0) begin
            if (!res.enable || task_offset[i] < res.value)
               res.value = task_offset[i];
            res.enable = 1'b1;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- reporting
   task automatic note_fault(input string msg);
      fault_count++;
      // keep the log bounded if the block goes badly wrong
      if (fault_count <= 100)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------- request side

   // Record each accepted transaction at the edge that takes it and predict its response.
   always @(posedge clock) begin : req_capture
      sched_item_type seen;
      req_accepted = !reset && req_valid && req_ready;
      if (req_accepted) begin
         seen.op     = req_operation;
         seen.index  = req_task_index;
         seen.period = req_period_ticks;
         seen.now    = req_counter_now;
         awaited_outcomes.push_back(schedule_step(seen));
         accepted_count <= accepted_count + 1;
      end
   end

   // Driver: presents the next pending transaction on the falling edge, holding the
   // payload steady until it has been taken; idles now and then outside the calm window.
   always @(negedge clock) begin : req_driver
      sched_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
            nxt = pending_items.pop_front();
            req_operation    <= nxt.op;
            req_task_index   <= nxt.index;
            req_period_ticks <= nxt.period;
            req_counter_now  <= nxt.now;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- response side

   // Long hold-off once, mid-run: the result register fills and req_ready must drop
   // while the driver keeps offering.
   always @(posedge clock) begin : rsp_hold
      if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin : rsp_driver
      rsp_ready <= !reset && hold_left == 0 && (calm || $urandom_range(0, 99) >= 8);
   end

   // Monitor: each response taken is checked field by field against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      sched_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outcomes.size() == 0) begin
            note_fault("response with no transaction outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_fired_mask !== want.fired)
               note_fault($sformatf("fired_mask %b, predicted %b", rsp_fired_mask, want.fired));
            if (rsp_compare_value !== want.value)
               note_fault($sformatf("compare_value %0d, predicted %0d",
                                    rsp_compare_value, want.value));
            if (rsp_compare_enable !== want.enable)
               note_fault($sformatf("compare_enable %b, predicted %b",
                                    rsp_compare_enable, want.enable));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   function automatic void enqueue(input logic [OP_W-1:0]     op,
                                   input logic [IDX_IN_W-1:0] idx,
                                   input logic [PERIOD_W-1:0] period,
                                   input logic [COUNT_W-1:0]  now);
      sched_item_type it;
      it.op     = op;
      it.index  = idx;
      it.period = period;
      it.now    = now;
      pending_items.push_back(it);
      queued_count++;
   endfunction

   // Wait until every transaction is in and answered, then let the block sit quiet
   // for the settle time before the next phase.
   task automatic wait_drained();
      while (accepted_count != queued_count || awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Counter top is only ever written with the block idle.
   task automatic write_top(input logic [COUNT_W-1:0] top);
      @(negedge clock);
      csr_counter_top <= top;
      csr_valid       <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      top_shadow = top;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic shaped like a real timer: a counter that runs up to top and
   // wraps, with compare events along the way, arms in between and some noise.
   task automatic run_timeline(input int count);
      int                  roll;
      int                  top_i;
      int                  span;
      int                  sim_now;
      logic [PERIOD_W-1:0] per;
      top_i   = int'(top_shadow);
      span    = top_i / 4 + 1;
      sim_now = int'($urandom_range(0, top_i));
      repeat (count) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 12) begin
            // anything the fields allow, spare operation and bad index included
            enqueue(OP_W'($urandom_range(0, 3)), IDX_IN_W'($urandom_range(0, 3)),
                    PERIOD_W'($urandom), COUNT_W'($urandom));
         end else if (roll < 34) begin
            case ($urandom_range(0, 3))
               0:       per = PERIOD_W'($urandom_range(0, 64));
               1:       per = PERIOD_W'($urandom_range(0, 3 * top_i + 3));
               2:       per = PERIOD_W'($urandom);
               default: per = PERIOD_W'(top_i * int'($urandom_range(1, 3))
                                        + int'($urandom_range(0, 2)) - 1);
            endcase
            enqueue(ttcs_pkg::OP_ARM, IDX_IN_W'($urandom_range(0, TASKS - 1)), per,
                    COUNT_W'(sim_now));
         end else begin
            sim_now += int'($urandom_range(0, span));
            if (sim_now > top_i) begin
               sim_now = sim_now % (top_i + 1);
               enqueue(ttcs_pkg::OP_WRAP, IDX_IN_W'($urandom_range(0, 3)),
                       PERIOD_W'($urandom), COUNT_W'(sim_now));
            end else begin
               enqueue(ttcs_pkg::OP_COMPARE, IDX_IN_W'($urandom_range(0, 3)),
                       PERIOD_W'($urandom), COUNT_W'(sim_now));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin : sequencer
      for (int i = 0; i < TASKS; i++) begin
         task_live[i]   = 1'b0;
         task_ticks[i]  = '0;
         task_wraps[i]  = '0;
         task_offset[i] = '0;
      end
      top_shadow = ttcs_pkg::TOP_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed transactions at the reset top of 65535
      enqueue(ttcs_pkg::OP_COMPARE, 2'd0, '0, 16'd0);        // nothing armed, nothing due
      enqueue(OP_SPARE,             2'd3, '1, '1);           // spare operation changes nothing
      enqueue(ttcs_pkg::OP_ARM,     2'd3, '1, '1);           // index past the last task
      enqueue(ttcs_pkg::OP_ARM,     2'd0, '0, 16'd0);        // zero period, due at once
      enqueue(ttcs_pkg::OP_COMPARE, 2'd0, '0, 16'd0);        // fires and re-arms in place
      enqueue(ttcs_pkg::OP_ARM,     2'd1, '1, '1);           // longest period from the top
      enqueue(ttcs_pkg::OP_ARM,     2'd2, 24'd100, 16'd65000);
      enqueue(ttcs_pkg::OP_COMPARE, 2'd0, '0, 16'd65099);    // one below task 2's offset
      enqueue(ttcs_pkg::OP_COMPARE, 2'd0, '0, '1);
      enqueue(ttcs_pkg::OP_WRAP,    2'd0, '0, 16'd0);
      enqueue(ttcs_pkg::OP_ARM,     2'd0, 24'd65535, 16'd0); // period equal to ticks left
      enqueue(ttcs_pkg::OP_WRAP,    '1,   '1, 16'd0);
      enqueue(ttcs_pkg::OP_COMPARE, 2'd0, '0, 16'd0);
      enqueue(ttcs_pkg::OP_ARM,     2'd1, 24'd1, '1);        // no ticks left before the wrap
      enqueue(ttcs_pkg::OP_COMPARE, 2'd0, '0, '1);
      enqueue(ttcs_pkg::OP_ARM,     2'd2, 24'h555555, 16'hAAAA);
      enqueue(ttcs_pkg::OP_ARM,     2'd2, 24'hAAAAAA, 16'h5555);
      enqueue(ttcs_pkg::OP_WRAP,    '1,   '1, '1);
      enqueue(ttcs_pkg::OP_COMPARE, '1,   '1, 16'd0);
      wait_drained();

      // mid-range top; count beyond top checked directly
      write_top(16'd1000);
      enqueue(ttcs_pkg::OP_ARM, 2'd2, 24'd50, 16'd40000);
      run_timeline(150);
      wait_drained();

      // top of one: saturating wrap count from the top
      write_top(16'd1);
      enqueue(ttcs_pkg::OP_ARM, 2'd0, '1, 16'd1);
      run_timeline(80);
      wait_drained();

      // zero top divides as one
      write_top(16'd0);
      enqueue(ttcs_pkg::OP_ARM, 2'd1, '1, 16'd0);
      run_timeline(60);
      wait_drained();

      // full-range top, with the response hold-off falling in this phase
      write_top(16'hFFFF);
      run_timeline(120);
      wait_drained();

      write_top(COUNT_W'($urandom_range(2, 65534)));
      run_timeline(100);
      wait_drained();

      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
